@@ hdl/dcsk_pkg.sv @@
package dcsk_pkg;
    localparam int MAX_HALF_LEN = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
    localparam int ADDR_W       = $clog2(MAX_HALF_LEN);
    localparam int CNT_W        = $clog2(MAX_HALF_LEN + 1);
    localparam int SUM_W        = SAMPLE_WIDTH + CNT_W;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;
    // centred chips need one bit above the sample width
    localparam int DW           = SAMPLE_WIDTH + 1;
    // divider numerator: a centred magnitude with the fraction bits below it
    localparam int DIV_NW       = DW + FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN = 1'd1;

    localparam logic signed [SAMPLE_WIDTH-1:0] Q_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Q_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_MEAN,
        S_CTR_RD,
        S_CTR_WR,
        S_SCL_RD,
        S_SCL_DIV,
        S_SCL_WR,
        S_LOAD,
        S_EMIT
    } t_state;

    // saturating negate
    function automatic logic signed [SAMPLE_WIDTH-1:0] neg_sat(
        input logic signed [SAMPLE_WIDTH-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v == Q_MIN) r = Q_MAX;
        else            r = -v;
        return r;
    endfunction
endpackage

@@ hdl/dcsk_ram.sv @@
module dcsk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hdl/dcsk_div.sv @@
// Restoring divider: quotient = num / den, one bit a cycle
module dcsk_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dcsk_pkg::DIV_NW-1:0] i_num,
    input  logic [dcsk_pkg::DW-1:0]     i_den,
    output logic                        o_done,
    output logic [dcsk_pkg::DW-1:0]     o_quot
);
    import dcsk_pkg::*;

    localparam int SW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_num, n_num;
    logic [DW:0]       r_rem, n_rem;
    logic [DW-1:0]     r_den;
    logic [DIV_NW-1:0] r_quot, n_quot;
    logic [SW-1:0]     r_cnt;
    logic              r_busy, r_done;
    logic [DW:0]       trial;

    always_comb begin
        trial  = {r_rem[DW-1:0], r_num[DIV_NW-1]};
        n_num  = {r_num[DIV_NW-2:0], 1'b0};
        if (trial >= {1'b0, r_den}) begin
            n_rem  = trial - {1'b0, r_den};
            n_quot = {r_quot[DIV_NW-2:0], 1'b1};
        end else begin
            n_rem  = trial;
            n_quot = {r_quot[DIV_NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    // callers keep the quotient within 2^FRAC_BITS (mean or scaled chip)
    assign o_done = r_done;
    assign o_quot = r_quot[DW-1:0];
endmodule

@@ hdl/dcsk_chaotic_modulator_top.sv @@
// DCSK modulator. After reset or any configuration write the first symbol
// first rebuilds the chip store for N chips, N being half_len clamped to
// 1..32: N map steps (one a cycle), a mean division on the bit-serial
// divider, a centring pass (a read and a write state per chip), a scaling
// pass (a read, a divide on the divider and a write per chip) and a load
// step to prime the memory read. Each symbol then streams 2*N samples, one
// per cycle while the output is not stalled, from the chip memory through an
// output register; no new request is taken while a symbol is in progress.
module dcsk_chaotic_modulator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dcsk_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dcsk_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_symbol_bit,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [dcsk_pkg::SAMPLE_WIDTH-1:0] o_sample,
    output logic                                  o_in_reference_half,
    output logic                                  o_last_of_symbol
);
    import dcsk_pkg::*;

    t_state r_state, n_state;
    logic signed [15:0]          r_seed;
    logic [5:0]                  r_half_len;
    logic                        r_store_valid;
    logic [CNT_W-1:0]            r_n;
    logic                        r_plus;
    logic [CNT_W-1:0]            r_i;
    logic [CNT_W:0]              r_k;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SAMPLE_WIDTH-1:0] r_mean;
    logic [DW-1:0]               r_max;
    logic signed [DW-1:0]        r_d;

    // output register
    logic                        r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_osample;
    logic                        r_oref, r_olast;

    // memory
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
    logic [DW-1:0]               mem_wdata, mem_rdata;

    dcsk_ram #(.WIDTH(DW), .DEPTH(MAX_HALF_LEN)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // divider, shared by mean and scaling
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num;
    logic [DW-1:0]     div_den, div_q;
    dcsk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // effective half length
    logic [CNT_W-1:0] eff_n;
    always_comb begin
        if (r_half_len == '0)                   eff_n = CNT_W'(1);
        else if (32'(r_half_len) > MAX_HALF_LEN) eff_n = CNT_W'(MAX_HALF_LEN);
        else                                    eff_n = CNT_W'(r_half_len);
    end

    // seed to Q1.F
    logic signed [SAMPLE_WIDTH-1:0] seed_q;
    always_comb begin
        if (FRAC_BITS >= 15) seed_q = SAMPLE_WIDTH'(32'(r_seed) <<< (FRAC_BITS - 15));
        else                 seed_q = SAMPLE_WIDTH'(32'(r_seed) >>> (15 - FRAC_BITS));
    end

    // map step
    logic [SAMPLE_WIDTH-1:0]     x_mag;
    logic [2*SAMPLE_WIDTH-1:0]   x_sq;
    logic [2*SAMPLE_WIDTH-1:0]   x_t;
    logic signed [2*SAMPLE_WIDTH+1:0] x_nxt_w;
    logic signed [SAMPLE_WIDTH-1:0]   x_nxt;
    always_comb begin
        x_mag   = r_x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-r_x) : SAMPLE_WIDTH'(r_x);
        x_sq    = x_mag * x_mag;
        x_t     = (x_sq + (2*SAMPLE_WIDTH)'(1 << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
        x_nxt_w = (2*SAMPLE_WIDTH+2)'(1 << FRAC_BITS) - $signed({2'b00, x_t});
        if (x_nxt_w > (2*SAMPLE_WIDTH+2)'(Q_MAX))       x_nxt = Q_MAX;
        else if (x_nxt_w < -(2*SAMPLE_WIDTH+2)'(1 << FRAC_BITS)) x_nxt = Q_MIN;
        else                                            x_nxt = SAMPLE_WIDTH'(x_nxt_w);
    end

    // centred value and magnitudes
    logic signed [DW-1:0] d_cur;
    logic [DW-1:0]        d_mag, rd_mag;
    logic signed [SUM_W-1:0] sum_mag;
    always_comb begin
        d_cur  = $signed(mem_rdata) - DW'(r_mean);
        d_mag  = d_cur[DW-1] ? DW'(-d_cur) : DW'(d_cur);
        rd_mag = mem_rdata[DW-1] ? DW'(-$signed(mem_rdata)) : mem_rdata;
        sum_mag = r_sum[SUM_W-1] ? -r_sum : r_sum;
    end

    // scaled chip
    logic signed [SAMPLE_WIDTH-1:0] chip_q;
    always_comb begin
        if (r_max == '0)                           chip_q = '0;
        else if (div_q[DW-1:FRAC_BITS] != '0)      chip_q = r_d[DW-1] ? Q_MIN : Q_MAX;
        else if (r_d[DW-1])                        chip_q = -$signed({1'b0, div_q[FRAC_BITS-1:0]});
        else                                       chip_q = $signed({1'b0, div_q[FRAC_BITS-1:0]});
    end

    logic out_free;
    assign out_free = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = r_store_valid ? S_EMIT : S_MAP;
            S_MAP:     if (r_i == r_n - 1'b1) n_state = S_MEAN;
            S_MEAN:    if (div_done) n_state = S_CTR_RD;
            S_CTR_RD:  n_state = S_CTR_WR;
            S_CTR_WR:  n_state = (r_i == r_n - 1'b1) ? S_SCL_RD : S_CTR_RD;
            S_SCL_RD:  n_state = S_SCL_DIV;
            S_SCL_DIV: if (div_done) n_state = S_SCL_WR;
            S_SCL_WR:  n_state = (r_i == r_n - 1'b1) ? S_LOAD : S_SCL_RD;
            S_LOAD:    n_state = S_EMIT;
            S_EMIT:    if (out_free && r_k == {r_n, 1'b0}) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic emit_adv;
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i[ADDR_W-1:0];
        mem_wdata = '0;
        mem_raddr = r_i[ADDR_W-1:0];
        div_start = 1'b0;
        div_num   = DIV_NW'(sum_mag);
        div_den   = DW'(r_n);
        emit_adv  = 1'b0;
        case (r_state)
            S_MAP: begin
                mem_we    = 1'b1;
                mem_wdata = DW'(x_nxt);
            end
            S_CTR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = d_cur;
            end
            S_SCL_DIV: begin
                div_num   = {rd_mag, {FRAC_BITS{1'b0}}};
                div_den   = r_max;
            end
            S_SCL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = DW'(chip_q);
                div_num   = {rd_mag, {FRAC_BITS{1'b0}}};
                div_den   = r_max;
            end
            S_EMIT: begin
                emit_adv  = out_free && (r_k != {r_n, 1'b0});
                mem_raddr = (r_k[CNT_W:0] >= {1'b0, r_n}) ?
                    ADDR_W'(r_k - {1'b0, r_n}) : ADDR_W'(r_k);
                if (out_free) begin
                    if (r_k + 1'b1 >= {1'b0, r_n})
                        mem_raddr = ADDR_W'(r_k + 1'b1 - {1'b0, r_n});
                    else
                        mem_raddr = ADDR_W'(r_k + 1'b1);
                end
            end
            default: ;
        endcase
        if (r_state == S_MEAN && r_i == '0 && !div_done && r_k == '0) div_start = 1'b1;
        if (r_state == S_SCL_RD) div_start = 1'b0;
        if (r_state == S_SCL_DIV && r_k == '0) div_start = 1'b1;
    end

    assign o_ready = (r_state == S_IDLE);

    // sequencer registers
    logic [CNT_W:0] emit_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_seed        <= 16'sd9830;
            r_half_len    <= 6'd16;
            r_store_valid <= 1'b0;
            r_ovalid      <= 1'b0;
            r_i           <= '0;
            r_k           <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SEED: begin
                        r_seed        <= $signed(i_cfg_data[15:0]);
                        r_store_valid <= 1'b0;
                    end
                    REG_HALF_LEN: begin
                        r_half_len    <= i_cfg_data[5:0];
                        r_store_valid <= 1'b0;
                    end
                    default: ;
                endcase
            end
            // load on a new sample, drop once taken
            if (emit_adv)     r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    r_k <= '0;
                    if (i_valid) begin
                        r_plus <= i_symbol_bit;
                        r_n    <= eff_n;
                        r_x    <= seed_q;
                        r_sum  <= '0;
                        r_max  <= '0;
                    end
                end
                S_MAP: begin
                    r_x   <= x_nxt;
                    r_sum <= r_sum + SUM_W'(x_nxt);
                    r_i   <= (r_i == r_n - 1'b1) ? '0 : r_i + 1'b1;
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean <= r_sum[SUM_W-1] ? -SAMPLE_WIDTH'(div_q) : SAMPLE_WIDTH'(div_q);
                        r_k    <= '0;
                    end else begin
                        r_k    <= (CNT_W+1)'(1);
                    end
                end
                S_CTR_WR: begin
                    if (d_mag > r_max) r_max <= d_mag;
                    r_i <= (r_i == r_n - 1'b1) ? '0 : r_i + 1'b1;
                end
                S_SCL_RD: r_k <= '0;
                S_SCL_DIV: begin
                    r_d <= $signed(mem_rdata);
                    r_k <= (CNT_W+1)'(1);
                end
                S_SCL_WR: begin
                    r_i <= (r_i == r_n - 1'b1) ? '0 : r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_store_valid <= 1'b1;
                        r_k           <= '0;
                    end
                end
                S_EMIT: begin
                    if (emit_adv) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // load output register from memory
    assign emit_idx = r_k;
    always_ff @(posedge i_clk) begin
        if (emit_adv) begin
            r_oref    <= emit_idx < {1'b0, r_n};
            r_olast   <= emit_idx == {r_n, 1'b0} - 1'b1;
            if (emit_idx >= {1'b0, r_n} && !r_plus)
                r_osample <= neg_sat($signed(mem_rdata[SAMPLE_WIDTH-1:0]));
            else
                r_osample <= $signed(mem_rdata[SAMPLE_WIDTH-1:0]);
        end
    end

    assign o_valid             = r_ovalid;
    assign o_sample            = r_osample;
    assign o_in_reference_half = r_oref;
    assign o_last_of_symbol    = r_olast;
endmodule

@@ hdl/dcsk_checker.sv @@
module dcsk_checker
    import dcsk_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [SAMPLE_WIDTH-1:0] o_sample,
    input logic                    o_in_reference_half,
    input logic                    o_last_of_symbol
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample))
        else $error("stalled result changed");

    // no new request while a symbol is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready during symbol");

    // the last sample is never a reference chip
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_last_of_symbol && o_in_reference_half))
        else $error("last sample in reference half");
endmodule

bind dcsk_chaotic_modulator_top dcsk_checker u_chk (.*);

@@ sim/dcsk_chaotic_modulator_top_test.sv @@
module dcsk_chaotic_modulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcsk_pkg::*;

    localparam int  RAND_SYMBOLS = 450;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam logic [CFG_W-1:0] SEED_RESET = 16'd9830;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           ref_half;
        logic                           last;
    } t_chip_out;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_W-1:0]               i_cfg_data;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_symbol_bit;
    logic                           o_valid;
    logic                           i_ready;
    logic signed [SAMPLE_WIDTH-1:0] o_sample;
    logic                           o_in_reference_half;
    logic                           o_last_of_symbol;

    // predictor state
    logic signed [15:0]             pm_seed;
    logic [5:0]                     pm_half_len;
    logic signed [SAMPLE_WIDTH-1:0] pm_chips [MAX_HALF_LEN];
    bit                             pm_chips_valid;

    bit        symbol_queue [$];
    t_chip_out chip_queue [$];
    int        err_count;
    int        cycle_count;
    int        drv_gap;
    int        mon_gap;
    bit        stim_done;

    dcsk_chaotic_modulator_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_symbol_bit        (i_symbol_bit),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_sample            (o_sample),
        .o_in_reference_half (o_in_reference_half),
        .o_last_of_symbol    (o_last_of_symbol)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int chip_count();
        if (pm_half_len == 0) return 1;
        if (pm_half_len > MAX_HALF_LEN) return MAX_HALF_LEN;
        return int'(pm_half_len);
    endfunction

    function automatic longint sat_q(longint v);
        if (v > (longint'(1) << FRAC_BITS) - 1) return (longint'(1) << FRAC_BITS) - 1;
        if (v < -(longint'(1) << FRAC_BITS)) return -(longint'(1) << FRAC_BITS);
        return v;
    endfunction

    // rebuild the chip sequence from seed: map, centre, scale
    task automatic build_chips();
        int     n;
        longint x, sq, t, total, mean, d, mag, peak, q;
        longint vals [MAX_HALF_LEN];
        n = chip_count();
        x = longint'(pm_seed) <<< (FRAC_BITS - 15);
        total = 0;
        for (int i = 0; i < n; i++) begin
            sq = (x < 0 ? -x : x) * (x < 0 ? -x : x);
            t = (sq + (longint'(1) << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
            x = sat_q((longint'(1) << FRAC_BITS) - t);
            vals[i] = x;
            total += x;
        end
        mean = total / n;
        peak = 0;
        for (int i = 0; i < n; i++) begin
            vals[i] = vals[i] - mean;
            mag = vals[i] < 0 ? -vals[i] : vals[i];
            if (mag > peak) peak = mag;
        end
        for (int i = 0; i < n; i++) begin
            d = vals[i];
            if (peak == 0) begin
                q = 0;
            end else begin
                mag = d < 0 ? -d : d;
                q = (mag << FRAC_BITS) / peak;
                q = sat_q(d < 0 ? -q : q);
            end
            pm_chips[i] = q[SAMPLE_WIDTH-1:0];
        end
        pm_chips_valid = 1'b1;
    endtask

    // queue the expected samples of one symbol
    task automatic predict_symbol(input bit plus);
        int        n;
        t_chip_out c;
        longint    v;
        if (!pm_chips_valid) build_chips();
        n = chip_count();
        for (int i = 0; i < 2 * n; i++) begin
            v = pm_chips[i < n ? i : i - n];
            if (i >= n && !plus) v = sat_q(-v);
            c.sample   = v[SAMPLE_WIDTH-1:0];
            c.ref_half = (i < n);
            c.last     = (i == 2 * n - 1);
            chip_queue = {chip_queue, c};
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // driver: present queued symbols, random gaps between requests
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_gap <= 0;
        end else if (i_valid && o_ready) begin
            predict_symbol(i_symbol_bit);
            if (drv_gap == 0 && symbol_queue.size() > 0 && $urandom_range(0, 1) == 0) begin
                i_symbol_bit <= symbol_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
                drv_gap <= pick_gap();
            end
        end else if (!i_valid) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
            end else if (symbol_queue.size() > 0) begin
                i_valid      <= 1'b1;
                i_symbol_bit <= symbol_queue.pop_front();
            end
        end
    end

    // monitor: compare each sample against the oldest expectation
    always @(posedge i_clk) begin
        t_chip_out want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (chip_queue.size() == 0) begin
                    $display("%0t: unexpected sample %0d ref %0b last %0b", $time,
                             o_sample, o_in_reference_half, o_last_of_symbol);
                    err_count++;
                end else begin
                    want = chip_queue.pop_front();
                    if (o_sample !== want.sample) begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 want.sample, o_sample);
                        err_count++;
                    end
                    if (o_in_reference_half !== want.ref_half) begin
                        $display("%0t: in_reference_half expected %0b actual %0b", $time,
                                 want.ref_half, o_in_reference_half);
                        err_count++;
                    end
                    if (o_last_of_symbol !== want.last) begin
                        $display("%0t: last_of_symbol expected %0b actual %0b", $time,
                                 want.last, o_last_of_symbol);
                        err_count++;
                    end
                end
            end
            // hold ready for stretches, drop it for random gaps
            if (mon_gap > 0) begin
                i_ready <= 1'b0;
                mon_gap <= mon_gap - 1;
            end else if ($urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                mon_gap <= pick_gap();
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // wait until all symbols are accepted and all samples seen, then settle
    task automatic drain();
        while (symbol_queue.size() > 0 || i_valid || chip_queue.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_SEED) pm_seed = val;
        else                 pm_half_len = val[5:0];
        pm_chips_valid = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] seed_val, input logic [5:0] len_val,
                             input int count);
        write_reg(REG_SEED, seed_val);
        write_reg(REG_HALF_LEN, {10'd0, len_val});
        for (int i = 0; i < count; i++) symbol_queue = {symbol_queue, 1'($urandom)};
        drain();
    endtask

    initial begin
        int share;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_SEED;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_symbol_bit = 1'b0;
        i_ready      = 1'b0;
        err_count    = 0;
        cycle_count  = 0;
        drv_gap      = 0;
        mon_gap      = 0;
        stim_done    = 1'b0;
        pm_seed      = SEED_RESET;
        pm_half_len  = 6'd16;
        pm_chips_valid = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, both symbol values
        symbol_queue = '{1'b1, 1'b0, 1'b0, 1'b1};
        drain();
        // rewrite same value: store must be rebuilt
        write_reg(REG_SEED, SEED_RESET);
        symbol_queue = '{1'b0, 1'b1};
        drain();
        // extremes of seed and half length, zero and over-range length
        run_phase(16'h8000, 6'd32, 3);
        run_phase(16'h7FFF, 6'd1, 3);
        run_phase(16'h0000, 6'd0, 2);
        run_phase(16'h4000, 6'd63, 2);
        run_phase(16'hFFFF, 6'd33, 2);
        run_phase(16'hC000, 6'd2, 3);
        run_phase(16'h5A82, 6'd5, 3);

        // random phases, mostly short lengths
        for (int p = 0; p < 15; p++) begin
            share = RAND_SYMBOLS / 15;
            run_phase(16'($urandom),
                      ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8)),
                      share);
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/dcsk_pkg.sv
hdl/dcsk_ram.sv
hdl/dcsk_div.sv
hdl/dcsk_chaotic_modulator_top.sv
hdl/dcsk_checker.sv
sim/dcsk_chaotic_modulator_top_test.sv
